// File: design/lru_key_value_cache_macros.svh
// Assertion macros for the key-value cache.
// Included by the top level, which checks its own logic; no other dependencies.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent check on an explicit clock and synchronous reset.
`define LKV_ASSERT_CLK(lbl, clk_i, rst_i, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (prop)) else $error(msg);
// Concurrent check on the module's clk and rst.
`define LKV_ASSERT(lbl, prop, msg) \
  `LKV_ASSERT_CLK(lbl, clk, rst, prop, msg)
`else
`define LKV_ASSERT_CLK(lbl, clk_i, rst_i, prop, msg)
`define LKV_ASSERT(lbl, prop, msg)
`endif

`endif

// File: design/lru_kv_pkg.sv
// Shared types and constants of the key-value cache.
// No dependencies; imported by the cell, the top level, the checker and the testbench.
package lru_kv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  // Per-item control broadcast along the row of cells.
  typedef struct packed {
    logic step;     // the item reorders the row (a put, or a get that hits)
    logic any_hit;  // some live cell matched the key
  } cell_ctl_t;

endpackage

// File: design/lru_key_value_cache.sv
// Top level of the fully associative key-value cache with LRU replacement.
// Depends on lru_kv_pkg, lru_kv_cell and lru_key_value_cache_macros.svh.
//
// Usage:
//   Requests arrive on the s_axis channel: tuser carries the command (get or
//   put), tdata carries key in bits 31:0 and value in bits 63:32. A get beat
//   produces exactly one response beat on m_axis: tuser is the hit flag and
//   tdata the stored value (zero on a miss). A put beat produces no response.
//   The capacity register is written through cfg_we/cfg_wdata while idle.
//
//   Entries sit in a row of cells in recency order, most recent in cell 0.
//   Every cell compares its key in parallel; on a reorder each cell either
//   keeps its entry or takes its neighbour's, in the same cycle.
//   A get's response is registered and appears in the cycle after the request
//   beat. Throughput: one request per cycle while the response side keeps up,
//   set by the compare-and-shift of the cell row.
//   Reset empties the cache (entry count zero) and sets capacity to 16.
//   When the response receiver stalls with a response pending, s_axis_tready
//   drops until that beat has been taken.
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache
  import lru_kv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_wdata,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [KEY_W+VAL_W-1:0]   s_axis_tdata,   // [31:0] key, [63:32] value
  input  logic                     s_axis_tuser,   // [0] cmd
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [VAL_W-1:0]         m_axis_tdata,   // [31:0] data
  output logic                     m_axis_tuser    // [0] hit
);

  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] eff_cap;

  logic             in_acc;
  cmd_t             cmd;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_value;

  cell_ctl_t        ctl;
  logic [MAX_ENTRIES-1:0] match_vec;
  logic [MAX_ENTRIES:0]   hit_chain;
  logic [KEY_W-1:0] cell_key   [MAX_ENTRIES];
  logic [VAL_W-1:0] cell_value [MAX_ENTRIES];
  logic [VAL_W-1:0] hit_value;
  logic [VAL_W-1:0] front_value;

  logic             out_valid;
  logic             out_hit;
  logic [VAL_W-1:0] out_data;

  assign cmd      = cmd_t'(s_axis_tuser);
  assign in_key   = s_axis_tdata[KEY_W-1:0];
  assign in_value = s_axis_tdata[KEY_W+VAL_W-1:KEY_W];

  // The response register frees up whenever its beat is taken, so a new
  // request may enter in the very cycle the old response leaves.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Capacity register; anything above the row length acts as the row length.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  assign eff_cap = (32'(capacity) > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                       : CNT_W'(capacity);

  // Row of cells. The hit chain tells each cell whether a match lies in
  // front of it, which freezes it for that reorder.
  assign hit_chain[0] = 1'b0;
  assign ctl.any_hit  = hit_chain[MAX_ENTRIES];
  assign ctl.step     = in_acc && (cmd == CMD_PUT || ctl.any_hit);

  // The new front entry always carries the request key: on a hit it equals
  // the matching key, on an insert it is the key being stored.
  assign front_value = (cmd == CMD_PUT) ? in_value : hit_value;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0] prev_key;
    logic [VAL_W-1:0] prev_value;

    if (i == 0) begin : g_front
      assign prev_key   = in_key;
      assign prev_value = front_value;
    end else begin : g_link
      assign prev_key   = cell_key[i-1];
      assign prev_value = cell_value[i-1];
    end

    lru_kv_cell u_cell (
      .clk        (clk),
      .search_key (in_key),
      .live       (CNT_W'(i) < count),
      .in_range   (CNT_W'(i) <= count),
      .ctl        (ctl),
      .hit_in     (hit_chain[i]),
      .hit_out    (hit_chain[i+1]),
      .match      (match_vec[i]),
      .prev_key   (prev_key),
      .prev_value (prev_value),
      .key        (cell_key[i]),
      .value      (cell_value[i])
    );
  end

  // Live keys are unique, so at most one cell matches and an OR picks its value.
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_value = hit_value | (match_vec[i] ? cell_value[i] : '0);
    end
  end

  // Entry count. A put that hits may drop one entry when over capacity; a
  // put that misses grows the row unless that would exceed capacity, in
  // which case the least recent entry falls off the end instead.
  always_comb begin
    count_next = count;
    if (in_acc && cmd == CMD_PUT) begin
      if (ctl.any_hit) begin
        if (count > eff_cap) begin
          count_next = count - CNT_W'(1);
        end
      end else if (32'(count) < 32'(MAX_ENTRIES) && count < eff_cap) begin
        count_next = count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && cmd == CMD_GET) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && cmd == CMD_GET) begin
      out_hit  <= ctl.any_hit;
      out_data <= ctl.any_hit ? hit_value : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_hit;
  assign m_axis_tdata  = out_data;

  `LKV_ASSERT(a_single_match, $onehot0(match_vec), "more than one live cell matched")
  `LKV_ASSERT(a_count_bound, 32'(count) <= 32'(MAX_ENTRIES), "entry count beyond row")
  `LKV_ASSERT(a_get_responds, (in_acc && cmd == CMD_GET) |=> out_valid, "get gave no response")
  `LKV_ASSERT(a_count_idle, !in_acc |=> $stable(count), "count moved without a request")
  `LKV_ASSERT(a_count_step, in_acc |=> (count == $past(count) || count == $past(count) + CNT_W'(1) || count + CNT_W'(1) == $past(count)), "count moved by more than one")

endmodule

// File: design/lru_kv_cell.sv
// One position of the recency row: a key and value with its compare.
// Depends on lru_kv_pkg.
module lru_kv_cell
  import lru_kv_pkg::*;
(
  input  logic             clk,
  input  logic [KEY_W-1:0] search_key,
  input  logic             live,
  input  logic             in_range,
  input  cell_ctl_t        ctl,
  input  logic             hit_in,
  output logic             hit_out,
  output logic             match,
  input  logic [KEY_W-1:0] prev_key,
  input  logic [VAL_W-1:0] prev_value,
  output logic [KEY_W-1:0] key,
  output logic [VAL_W-1:0] value
);

  logic shift;

  assign match   = live && (key == search_key);
  assign hit_out = hit_in || match;

  // Cells from the front up to the hit, or up to the insertion point on a miss,
  // take their neighbour's entry; everything behind stays put.
  assign shift = ctl.step && !hit_in && (ctl.any_hit || in_range);

  always_ff @(posedge clk) begin
    if (shift) begin
      key   <= prev_key;
      value <= prev_value;
    end
  end

endmodule

// File: sim/lru_cache_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the LRU key-value cache: watches the request, response and
// capacity ports, predicts each get reply and compares it with the block.
// Depends on lru_kv_pkg only.
module lru_cache_checker
  import lru_kv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CAP_W-1:0]       cfg_wdata,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [KEY_W+VAL_W-1:0] s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [VAL_W-1:0]       m_axis_tdata,
  input  logic                   m_axis_tuser,
  output int                     fail_count,
  output int                     pending_count
);

  localparam int IDX_W        = $clog2(MAX_ENTRIES);
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] data;
  } reply_t;

  // Shadow copy of the cache contents and its capacity register.
  logic [KEY_W-1:0] slot_key [MAX_ENTRIES];
  logic [VAL_W-1:0] slot_val [MAX_ENTRIES];
  logic [IDX_W-1:0] recency  [MAX_ENTRIES];
  int               live;
  logic [CAP_W-1:0] capacity;

  reply_t replies_due[$];
  int     n_bad = 0;
  int     n_seen = 0;

  // Recency position of a live key, or live on a miss.
  function automatic int find_key(input logic [KEY_W-1:0] k);
    for (int p = 0; p < live; p++) begin
      if (slot_key[recency[p]] == k) return p;
    end
    return live;
  endfunction

  function automatic void promote(input int pos);
    logic [IDX_W-1:0] slot;
    slot = recency[pos];
    for (int i = pos; i > 0; i--) recency[i] = recency[i - 1];
    recency[0] = slot;
  endfunction

  function automatic void store_pair(input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
    int pos;
    int lim;
    pos = find_key(k);
    lim = (int'(capacity) > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity);
    if (pos < live) begin
      promote(pos);
      slot_val[recency[0]] = v;
      if (live > lim) live--;
    end else if (live < MAX_ENTRIES) begin
      promote(live);
      slot_key[recency[0]] = k;
      slot_val[recency[0]] = v;
      live++;
      if (live > lim) live--;
    end else begin
      // Every slot is live, so the least recent one is recycled.
      promote(live - 1);
      slot_key[recency[0]] = k;
      slot_val[recency[0]] = v;
    end
  endfunction

  function automatic reply_t fetch(input logic [KEY_W-1:0] k);
    int     pos;
    reply_t r;
    pos = find_key(k);
    r.hit  = 1'b0;
    r.data = '0;
    if (pos < live) begin
      promote(pos);
      r.hit  = 1'b1;
      r.data = slot_val[recency[0]];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      for (int i = 0; i < MAX_ENTRIES; i++) recency[i] = IDX_W'(i);
      live     = 0;
      capacity = CAP_RESET;
      replies_due.delete();
    end else begin
      // A reply leaving now belongs to an earlier request, so check it first.
      if (m_axis_tvalid && m_axis_tready) begin
        n_seen++;
        if (replies_due.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_LIMIT)
            $display("[%0t] reply %0d with nothing outstanding: hit=%0b data=%h",
                     $time, n_seen, m_axis_tuser, m_axis_tdata);
        end else begin
          want = replies_due.pop_front();
          if (m_axis_tuser !== want.hit || m_axis_tdata !== want.data) begin
            n_bad++;
            if (n_bad <= REPORT_LIMIT)
              $display("[%0t] reply %0d: expected hit=%0b data=%h, got hit=%0b data=%h",
                       $time, n_seen, want.hit, want.data, m_axis_tuser, m_axis_tdata);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == CMD_PUT)
          store_pair(s_axis_tdata[KEY_W-1:0], s_axis_tdata[KEY_W +: VAL_W]);
        else
          replies_due.push_back(fetch(s_axis_tdata[KEY_W-1:0]));
      end
      if (cfg_we) capacity = cfg_wdata;
    end
    fail_count    <= n_bad;
    pending_count <= replies_due.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the LRU key-value cache testbench: clock, reset, request and reply
// drivers and the run sequence. Depends on lru_kv_pkg, lru_key_value_cache and
// lru_cache_checker.
module tb_top;
  import lru_kv_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 8;
  localparam int IDLE_PCT       = 16;
  localparam int HOLD_CYCLES    = 64;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASE_ITEMS    = 62;
  localparam int N_PHASES       = 10;
  localparam int CALM_PHASE     = 7;
  localparam int HOLD_PHASE     = 4;
  localparam int TIMEOUT_CYCLES = 200_000;
  localparam int POOL_MAX       = MAX_ENTRIES + 4;

  // Capacity of each random phase. The first follows a full cache, so it
  // exercises a capacity lowered while in use; zero and values above the
  // storage size are covered too. The last phase draws its own capacity.
  localparam int PHASE_CAP [N_PHASES] = '{2, 0, 31, 1, 16, 5, 3, 9, 16, 0};

  localparam logic [31:0] CORNER_WORDS [4] =
    '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CAP_W-1:0]       cfg_wdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [KEY_W+VAL_W-1:0] s_axis_tdata;   // [31:0] key, [63:32] value
  logic                   s_axis_tuser;   // [0] cmd
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [VAL_W-1:0]       m_axis_tdata;   // [31:0] data
  logic                   m_axis_tuser;   // [0] hit

  int fail_count;
  int pending_count;

  // When calm is set neither side inserts idle cycles. Each increment of
  // hold_requests asks the reply side for one long hold-off.
  bit calm = 1'b0;
  int hold_requests = 0;
  int holds_served = 0;

  // Keys of the current phase, four more than the capacity capped at the row
  // length, so that most requests meet live entries and evictions still happen.
  logic [KEY_W-1:0] key_pool [POOL_MAX];
  int               pool_n;

  lru_key_value_cache u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  lru_cache_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Safety net: the slowest correct run is a small fraction of this.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("lru_key_value_cache: mismatch");
    $finish;
  end

  // Reply side. Normally ready drops at random in about one cycle in six;
  // on request it holds off for a long stretch so that one reply sits
  // waiting and the cache has to stall its request side.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Offers one request beat and returns at the edge where it is taken, so
  // the next beat may follow without a gap.
  task automatic offer(input cmd_t c, input logic [KEY_W-1:0] k,
                       input logic [VAL_W-1:0] v);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c;
    s_axis_tdata  <= {v, k};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Stops offering, waits until every reply has come back and then lets a
  // put that was taken last settle inside the cache.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the capacity while idle and draws a fresh key pool to suit it.
  task automatic start_phase(input logic [CAP_W-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_n = ((int'(cap) > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap)) + 4;
    for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom();
  endtask

  // Most requests use keys of the pool; the rest are random keys that
  // almost always miss, and the odd corner pattern.
  task automatic random_request();
    int               roll;
    cmd_t             c;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    roll = $urandom_range(0, 99);
    c = ($urandom_range(0, 99) < 45) ? CMD_PUT : CMD_GET;
    v = ($urandom_range(0, 19) == 0) ? CORNER_WORDS[$urandom_range(0, 3)] : $urandom();
    if (roll < 85)
      k = key_pool[$urandom_range(0, pool_n - 1)];
    else if (roll < 95)
      k = $urandom();
    else
      k = CORNER_WORDS[$urandom_range(0, 3)];
    offer(c, k, v);
  endtask

  initial begin
    logic [CAP_W-1:0] cap;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_GET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset capacity of sixteen. A get on the empty
    // cache must miss, then the corner keys and values go in and come out.
    offer(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    offer(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    offer(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    offer(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    offer(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    offer(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    offer(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    offer(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    offer(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    // Keys one bit away from live ones must not match.
    offer(CMD_GET, 32'h0000_0001, 32'h0000_0000);
    offer(CMD_GET, 32'h8000_0001, 32'h0000_0000);
    // An update of a live key, read back; a get whose value field is busy.
    offer(CMD_PUT, 32'h0000_0000, 32'h1234_5678);
    offer(CMD_GET, 32'h0000_0000, 32'h0000_0000);
    offer(CMD_GET, 32'hFFFF_FFFF, 32'hAAAA_AAAA);
    // Fill every slot, then one more new key recycles the least recent slot,
    // which now holds 8000_0000; that key must be gone, the others stay.
    for (int i = 0; i < MAX_ENTRIES - 4; i++)
      offer(CMD_PUT, 32'h0000_0100 + i, ~(32'h0000_0100 + i));
    offer(CMD_PUT, 32'h5555_AAAA, 32'hA5A5_5A5A);
    offer(CMD_GET, 32'h8000_0000, 32'h0000_0000);
    offer(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    drain();

    // Random phases, each at its own capacity. One runs without any idling
    // and one starts with a long hold-off on the reply side.
    for (int p = 0; p < N_PHASES; p++) begin
      cap = (p == N_PHASES - 1) ? CAP_W'($urandom_range(0, 31)) : CAP_W'(PHASE_CAP[p]);
      start_phase(cap);
      calm = (p == CALM_PHASE);
      if (p == HOLD_PHASE) hold_requests++;
      for (int i = 0; i < PHASE_ITEMS; i++) random_request();
      drain();
    end
    calm = 1'b0;

    if (fail_count == 0 && pending_count == 0)
      $display("lru_key_value_cache: match");
    else
      $display("lru_key_value_cache: mismatch");
    $finish;
  end

endmodule
